// ===== rtl/tmsa_pkg.sv =====
// Package: shared constants, types and command/status structs for the trimmed-mean averager.
package tmsa_pkg;
   localparam int STORE_DEPTH  = 512;
   localparam int SAMPLE_WIDTH = 24;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int COUNT_W      = $clog2(STORE_DEPTH + 1);
   localparam int TRIM_W       = 7;
   localparam int KEPT_W       = 10;
   localparam int SUM_W        = SAMPLE_WIDTH + COUNT_W;
   localparam int PROD_W       = COUNT_W + TRIM_W;
   localparam int PERCENT      = 100;
   localparam int RECIP_SHIFT  = 24;
   localparam int RECIP        = ((1 << RECIP_SHIFT) + PERCENT - 1) / PERCENT;
   localparam logic [TRIM_W-1:0] TRIM_RESET = 7'd10;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [ADDR_W-1:0]              addr_type;
   typedef logic [COUNT_W-1:0]             count_type;

   typedef struct packed {
      logic     store;        // write req sample at count
      logic     clr_count;
      logic     rd_en;        // read mem at rd_addr
      addr_type rd_addr;
      logic     wr_en;        // write wr_data at wr_addr
      addr_type wr_addr;
      logic     ld_key;       // capture read data as key
      logic     shift_up;     // write last read data at j (wr_addr)
      logic     ld_trim;      // compute range
      logic     clr_sum;
      logic     acc;          // add read data to sum
      logic     div_start;
   } cmd_type;

   typedef struct packed {
      count_type count;
      logic      gt_key;      // last read data > key
      count_type lo;
      count_type hi;
      logic      div_done;
   } status_type;
endpackage

// ===== rtl/tmsa_if.sv =====
// Interfaces: request and response channels of the trimmed-mean averager.
interface tmsa_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [tmsa_pkg::SAMPLE_WIDTH-1:0] sample;
   logic                           last;
   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface tmsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [tmsa_pkg::SAMPLE_WIDTH-1:0] mean;
   logic [tmsa_pkg::KEPT_W-1:0]    kept_count;
   modport source (output valid, output mean, output kept_count, input ready);
   modport sink (input valid, input mean, input kept_count, output ready);
endinterface

// ===== rtl/tmsa_divider.sv =====
// Divider: sequential restoring signed division of the sum by the kept count.
module tmsa_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [tmsa_pkg::SUM_W-1:0]   dividend,
   input  tmsa_pkg::count_type                 divisor,
   output logic                                done,
   output logic signed [tmsa_pkg::SAMPLE_WIDTH-1:0] quotient
);
   localparam int W = tmsa_pkg::SUM_W;
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  q_ff, q_in;
   logic [W:0]    r_ff, r_in;
   logic [CW-1:0] n_ff, n_in;
   logic          busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [W:0]    trial;
   logic [W-1:0]  res;

   always_comb begin
      q_in = q_ff; r_in = r_ff; n_in = n_ff; busy_in = busy_ff; neg_in = neg_ff;
      done_in = 1'b0;
      trial = {r_ff[W-1:0], q_ff[W-1]} - {{(W + 1 - tmsa_pkg::COUNT_W){1'b0}}, divisor};
      if (start) begin
         q_in = dividend[W-1] ? W'(-dividend) : dividend;
         r_in = '0;
         n_in = CW'(W);
         neg_in = dividend[W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[W]) begin
            r_in = {r_ff[W-1:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end else begin
            r_in = trial;
            q_in = {q_ff[W-2:0], 1'b1};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; n_ff <= n_in; neg_ff <= neg_in;
   end

   assign res = neg_ff ? -q_ff : q_ff;
   assign done = done_ff;
   assign quotient = res[tmsa_pkg::SAMPLE_WIDTH-1:0];
endmodule

// ===== rtl/tmsa_datapath.sv =====
// Datapath: sample store, insertion-sort key, trim computation and sum accumulator.
module tmsa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tmsa_pkg::sample_type          in_sample,
   input  logic [tmsa_pkg::TRIM_W-1:0]   trim_value,
   input  tmsa_pkg::cmd_type             cmd,
   output tmsa_pkg::status_type          status,
   output tmsa_pkg::sample_type          mean
);
   tmsa_pkg::sample_type mem [tmsa_pkg::STORE_DEPTH];
   tmsa_pkg::sample_type rd_ff, key_ff;
   tmsa_pkg::count_type  count_ff, lo_ff, hi_ff, kept;
   logic [tmsa_pkg::PROD_W-1:0] prod_ff;
   logic [tmsa_pkg::PROD_W+tmsa_pkg::RECIP_SHIFT-1:0] scaled;
   tmsa_pkg::count_type  trim;
   logic                 stage_ff;
   logic signed [tmsa_pkg::SUM_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) mem[count_ff[tmsa_pkg::ADDR_W-1:0]] <= in_sample;
      else if (cmd.wr_en) mem[cmd.wr_addr] <= cmd.shift_up ? rd_ff : key_ff;
      if (cmd.rd_en) rd_ff <= mem[cmd.rd_addr];
      if (cmd.ld_key) key_ff <= rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.clr_count) count_ff <= '0;
      else if (cmd.store) count_ff <= count_ff + 1'b1;
   end

   assign scaled = prod_ff * tmsa_pkg::RECIP;
   assign trim = tmsa_pkg::count_type'(scaled >> tmsa_pkg::RECIP_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) stage_ff <= 1'b0;
      else stage_ff <= cmd.ld_trim;
      if (cmd.ld_trim)
         prod_ff <= tmsa_pkg::PROD_W'(count_ff) * tmsa_pkg::PROD_W'(trim_value);
      if (stage_ff) begin
         if ({1'b0, trim} + {1'b0, trim} >= {1'b0, count_ff}) begin
            lo_ff <= '0;
            hi_ff <= count_ff;
         end else begin
            lo_ff <= trim;
            hi_ff <= count_ff - trim;
         end
      end
      if (cmd.clr_sum) sum_ff <= '0;
      else if (cmd.acc) sum_ff <= sum_ff + tmsa_pkg::SUM_W'(rd_ff);
   end

   assign kept = hi_ff - lo_ff;

   tmsa_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(sum_ff),
      .divisor(kept), .done(status.div_done), .quotient(mean)
   );

   assign status.count  = count_ff;
   assign status.gt_key = rd_ff > key_ff;
   assign status.lo     = lo_ff;
   assign status.hi     = hi_ff;
endmodule

// ===== rtl/tmsa_controller.sv =====
// Controller: sequences collection, insertion sort, summation, division and output.
module tmsa_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tmsa_pkg::status_type status,
   output tmsa_pkg::cmd_type    cmd
);
   localparam logic [3:0] S_COLLECT = 4'd0, S_OUTER = 4'd1, S_KEYRD = 4'd2,
      S_KEY = 4'd3, S_CMPRD = 4'd4, S_CMP = 4'd5, S_TRIM0 = 4'd6, S_TRIM1 = 4'd7,
      S_SUMRD = 4'd8, S_SUM = 4'd9, S_DIV = 4'd10, S_WAIT = 4'd11, S_OUT = 4'd12;
   logic [3:0] state_ff, state_in;
   tmsa_pkg::count_type i_ff, i_in, j_ff, j_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff; i_in = i_ff; j_in = j_ff; rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      req_ready = (state_ff == S_COLLECT);
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_COLLECT: if (req_valid && req_ready) begin
            cmd.store = status.count < tmsa_pkg::count_type'(tmsa_pkg::STORE_DEPTH);
            if (req_last) begin
               state_in = S_OUTER;
               i_in = tmsa_pkg::count_type'(1);
            end
         end
         S_OUTER: begin
            if (i_ff >= status.count) state_in = S_TRIM0;
            else begin
               cmd.rd_en = 1'b1;
               cmd.rd_addr = i_ff[tmsa_pkg::ADDR_W-1:0];
               state_in = S_KEYRD;
            end
         end
         S_KEYRD: begin
            cmd.ld_key = 1'b1;
            j_in = i_ff;
            state_in = S_CMPRD;
         end
         S_CMPRD: begin
            if (j_ff == '0) begin
               cmd.wr_en = 1'b1;
               cmd.wr_addr = j_ff[tmsa_pkg::ADDR_W-1:0];
               i_in = i_ff + 1'b1;
               state_in = S_OUTER;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_addr = tmsa_pkg::addr_type'(j_ff - 1'b1);
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.wr_en = 1'b1;
            cmd.wr_addr = j_ff[tmsa_pkg::ADDR_W-1:0];
            if (status.gt_key) begin
               cmd.shift_up = 1'b1;
               j_in = j_ff - 1'b1;
               state_in = S_CMPRD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_OUTER;
            end
         end
         S_TRIM0: begin
            cmd.ld_trim = 1'b1;
            state_in = S_TRIM1;
         end
         S_TRIM1: begin
            state_in = S_KEY;
         end
         S_KEY: begin
            cmd.clr_sum = 1'b1;
            i_in = status.lo;
            state_in = S_SUMRD;
         end
         S_SUMRD: begin
            if (i_ff >= status.hi) state_in = S_DIV;
            else begin
               cmd.rd_en = 1'b1;
               cmd.rd_addr = i_ff[tmsa_pkg::ADDR_W-1:0];
               i_in = i_ff + 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.acc = 1'b1;
            state_in = S_SUMRD;
         end
         S_DIV: if (!rsp_valid_ff) begin
            cmd.div_start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: if (status.div_done) state_in = S_OUT;
         S_OUT: begin
            rsp_valid_in = 1'b1;
            cmd.clr_count = 1'b1;
            state_in = S_COLLECT;
         end
         default: state_in = S_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== rtl/trimmed_mean_sample_averager.sv =====
// Top level: trimmed-mean averager of signed converter samples.
// The req channel carries one sample per transaction, with last on the final
// sample of a set. Samples are taken one per cycle while collecting; those
// beyond the 512-entry store are dropped, but their last flag still closes
// the set. After last, the stored set is insertion-sorted in place through
// the single store port, trimmed by floor(n*trim_percent/100) at each end
// (all kept if that would leave none), summed one kept sample at a time,
// and divided by a 34-step serial divider. The rsp channel then presents
// mean and kept_count in an output register until taken. req_ready is low
// from the last sample until the result is registered. While a response
// waits, the next set is still collected and sorted, but its division
// holds until the response is taken.
// csr_wr_en loads trim_percent (reset 10); write only while idle.
// Synchronous reset clears the sample count, the state and the response
// valid; the store contents are not cleared.
module trimmed_mean_sample_averager (
   input  logic                         clock,
   input  logic                         reset,
   tmsa_req_if.sink                     req,
   tmsa_rsp_if.source                   rsp,
   input  logic                         csr_wr_en,
   input  logic [tmsa_pkg::TRIM_W-1:0]  csr_wr_data
);
   tmsa_pkg::cmd_type    cmd;
   tmsa_pkg::status_type status;
   tmsa_pkg::sample_type mean;
   logic [tmsa_pkg::TRIM_W-1:0] trim_ff;
   logic signed [tmsa_pkg::SAMPLE_WIDTH-1:0] mean_ff;
   logic [tmsa_pkg::KEPT_W-1:0] kept_ff;

   always_ff @(posedge clock) begin
      if (reset) trim_ff <= tmsa_pkg::TRIM_RESET;
      else if (csr_wr_en) trim_ff <= csr_wr_data;
      if (status.div_done) begin
         mean_ff <= mean;
         kept_ff <= tmsa_pkg::KEPT_W'(status.hi - status.lo);
      end
   end

   tmsa_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_last(req.last),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status(status), .cmd(cmd)
   );

   tmsa_datapath u_dp (
      .clock(clock), .reset(reset), .in_sample(req.sample), .trim_value(trim_ff),
      .cmd(cmd), .status(status), .mean(mean)
   );

   assign rsp.mean = mean_ff;
   assign rsp.kept_count = kept_ff;
endmodule

// ===== verif/tb_trimmed_mean_sample_averager.sv =====
// Testbench: trimmed-mean averager, directed table plus random sets checked by a predictor.
module tb_trimmed_mean_sample_averager;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 8000000;
   localparam int          ITEM_TARGET = 1150;

   typedef struct {
      logic [tmsa_pkg::SAMPLE_WIDTH-1:0] mean;
      logic [tmsa_pkg::KEPT_W-1:0]       kept;
   } avg_type;

   typedef struct {
      logic [tmsa_pkg::SAMPLE_WIDTH-1:0] sample;
      logic                              last;
      logic                              typed;
      logic [tmsa_pkg::SAMPLE_WIDTH-1:0] mean;
      logic [tmsa_pkg::KEPT_W-1:0]       kept;
   } row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [tmsa_pkg::TRIM_W-1:0] csr_wr_data;

   tmsa_req_if req ();
   tmsa_rsp_if rsp ();

   trimmed_mean_sample_averager i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req.sink),
      .rsp         (rsp.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   avg_type     pending_avgs[$];
   longint      set_samples[tmsa_pkg::STORE_DEPTH];
   int unsigned set_count;
   int unsigned trim_value;
   int unsigned mismatches;
   int unsigned cycles;
   int unsigned items_sent;
   int unsigned trim_choices[] = '{0, 100, 127, 25, 1, 99, 50, 64, 10};

   localparam logic [tmsa_pkg::SAMPLE_WIDTH-1:0] MAXS = 24'h7FFFFF;
   localparam logic [tmsa_pkg::SAMPLE_WIDTH-1:0] MINS = 24'h800000;

   row_type directed[] = '{
      '{MAXS, 1'b1, 1'b1, MAXS, 10'd1},
      '{MINS, 1'b1, 1'b1, MINS, 10'd1},
      '{MAXS, 1'b0, 1'b0, '0, '0},
      '{MAXS, 1'b1, 1'b1, MAXS, 10'd2},
      '{MINS, 1'b0, 1'b0, '0, '0},
      '{MINS, 1'b1, 1'b1, MINS, 10'd2},
      '{MAXS, 1'b0, 1'b0, '0, '0},
      '{MINS, 1'b1, 1'b1, 24'd0, 10'd2},
      '{24'hFFFFFF, 1'b0, 1'b0, '0, '0},
      '{24'hFFFFFE, 1'b1, 1'b1, 24'hFFFFFF, 10'd2},
      '{24'h000005, 1'b0, 1'b0, '0, '0},
      '{24'h000001, 1'b0, 1'b0, '0, '0},
      '{24'h000009, 1'b0, 1'b0, '0, '0},
      '{24'hFFFFF0, 1'b0, 1'b0, '0, '0},
      '{24'h000100, 1'b0, 1'b0, '0, '0},
      '{24'h000002, 1'b0, 1'b0, '0, '0},
      '{24'h000003, 1'b0, 1'b0, '0, '0},
      '{24'h000007, 1'b0, 1'b0, '0, '0},
      '{24'h000004, 1'b0, 1'b0, '0, '0},
      '{24'h000006, 1'b0, 1'b0, '0, '0},
      '{24'h000008, 1'b1, 1'b0, '0, '0}
   };

   function automatic avg_type trimmed_average();
      avg_type     r;
      longint      key;
      longint      sum;
      int unsigned n, cut, lo, hi, i, j;
      n = set_count;
      for (i = 1; i < n; i++) begin
         key = set_samples[i];
         j = i;
         while (j > 0 && set_samples[j-1] > key) begin
            set_samples[j] = set_samples[j-1];
            j--;
         end
         set_samples[j] = key;
      end
      cut = (n * trim_value) / 100;
      lo = cut;
      hi = (cut <= n) ? n - cut : 0;
      if (hi <= lo) begin
         lo = 0;
         hi = n;
      end
      sum = 0;
      for (i = lo; i < hi; i++) sum += set_samples[i];
      r.mean = tmsa_pkg::SAMPLE_WIDTH'(sum / longint'(hi - lo));
      r.kept = tmsa_pkg::KEPT_W'(hi - lo);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("trimmed_mean_sample_averager regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (reset) rsp.ready <= 1'b0;
      else if (cycles % 4000 < 1500) rsp.ready <= 1'b1;
      else if (cycles % 4000 >= 3880) rsp.ready <= 1'b0;
      else rsp.ready <= (roll < 70) || (roll < 72 && $urandom_range(0, 1) == 1);
   end

   always @(posedge clock) begin
      avg_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_avgs.size() == 0) begin
            report_mismatch("unexpected transaction", rsp.kept_count, 0);
         end else begin
            want = pending_avgs.pop_front();
            if (rsp.mean !== want.mean)
               report_mismatch("mean", $signed(rsp.mean), $signed(want.mean));
            if (rsp.kept_count !== want.kept)
               report_mismatch("kept_count", rsp.kept_count, want.kept);
         end
      end
   end

   task automatic send_sample(input logic [tmsa_pkg::SAMPLE_WIDTH-1:0] s, input logic l,
                              input logic typed, input avg_type typed_avg);
      int unsigned gap;
      avg_type     r;
      gap = ($urandom_range(0, 99) < 60) ? 0 :
            ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (cycles % 3000 < 800) gap = 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.sample <= s;
      req.last <= l;
      @(negedge clock);
      while (!req.ready) @(negedge clock);
      @(posedge clock);
      items_sent++;
      if (set_count < tmsa_pkg::STORE_DEPTH) begin
         set_samples[set_count] = longint'($signed(s));
         set_count++;
      end
      if (l) begin
         r = trimmed_average();
         pending_avgs.push_back(typed ? typed_avg : r);
         set_count = 0;
      end
   endtask

   task automatic write_trim(input int unsigned pct);
      req.valid <= 1'b0;
      while (pending_avgs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= tmsa_pkg::TRIM_W'(pct);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      trim_value = pct;
   endtask

   task automatic random_set(input int unsigned n);
      logic [tmsa_pkg::SAMPLE_WIDTH-1:0] s;
      avg_type none;
      none = '{'0, '0};
      for (int unsigned k = 0; k < n; k++) begin
         s = ($urandom_range(0, 3) == 0) ?
             tmsa_pkg::SAMPLE_WIDTH'($urandom_range(0, 40) - 20) :
             tmsa_pkg::SAMPLE_WIDTH'($urandom());
         send_sample(s, k == n - 1, 1'b0, none);
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned roll;
      avg_type     typed_avg;
      reset = 1'b1;
      req.valid = 1'b0;
      req.sample = '0;
      req.last = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      cycles = 0;
      mismatches = 0;
      items_sent = 0;
      set_count = 0;
      trim_value = 10;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < directed.size(); i++) begin
         if (i == 10) write_trim(100);
         typed_avg = '{directed[i].mean, directed[i].kept};
         send_sample(directed[i].sample, directed[i].last, directed[i].typed, typed_avg);
      end
      write_trim(0);
      random_set(3);

      // store overflow: extra samples dropped, last on a dropped sample still closes
      write_trim(10);
      random_set(tmsa_pkg::STORE_DEPTH + 3);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase % 12 == 0)
            write_trim(trim_choices[(phase / 12) % trim_choices.size()]);
         roll = $urandom_range(0, 99);
         random_set(roll < 70 ? $urandom_range(1, 8) :
                    roll < 96 ? $urandom_range(9, 40) : $urandom_range(41, 90));
         phase++;
      end
      write_trim(127);
      random_set(1);
      random_set(2);

      req.valid <= 1'b0;
      while (pending_avgs.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("trimmed_mean_sample_averager regression: pass");
      end else begin
         $display("trimmed_mean_sample_averager regression: fail");
      end
      $finish;
   end
endmodule
